FILE: rtl/adsr_pkg.sv
package adsr_pkg;

    // level format
    localparam int LEVEL_FRAC_BITS = 24;
    localparam int OUT_W   = LEVEL_FRAC_BITS + 1;   // reported level, steps, targets
    localparam int LEVEL_W = LEVEL_FRAC_BITS + 2;   // stored level, room for attack overshoot

    // field widths
    localparam int LEN_W = 20;
    localparam int SUS_W = 16;
    localparam int VEL_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // shared divider, wide enough for velocity scaled to a level
    localparam int DIV_W = LEVEL_FRAC_BITS + VEL_W;

    localparam logic [OUT_W-1:0] ONE_FX     = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
    localparam logic [OUT_W-1:0] HOLD_RESET = ONE_FX >> 1;
    localparam logic [LEN_W-1:0] VEL_SCALE  = LEN_W'(127);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(480);
    localparam logic [SUS_W-1:0] SUS_RESET = SUS_W'(32768);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN   = 2'd3;

    // item kinds
    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

    // envelope phases
    localparam logic [1:0] PH_ATTACK = 2'd0;
    localparam logic [1:0] PH_DECAY  = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_STEP,
        S_TICK_CHECK,
        S_PEAK_DIV,
        S_HOLD_MUL,
        S_ATK_DIV,
        S_DEC_DIV,
        S_REL_DIV,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0] attack_len;
        logic [LEN_W-1:0] decay_len;
        logic [SUS_W-1:0] sustain_level;
        logic [LEN_W-1:0] release_len;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic             release_done;
        logic             releasing;
        logic             released;
        logic [1:0]       phase;
        logic [OUT_W-1:0] level;
    } res_t;

endpackage

FILE: rtl/adsr_cfg.sv
module adsr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output adsr_pkg::cfg_t                   cfg
);

    adsr_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_len    <= adsr_pkg::LEN_RESET;
            cfg_reg.decay_len     <= adsr_pkg::LEN_RESET;
            cfg_reg.sustain_level <= adsr_pkg::SUS_RESET;
            cfg_reg.release_len   <= adsr_pkg::LEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                adsr_pkg::REG_ATTACK_LEN:
                    cfg_reg.attack_len <= cfg_data[adsr_pkg::LEN_W-1:0];
                adsr_pkg::REG_DECAY_LEN:
                    cfg_reg.decay_len <= cfg_data[adsr_pkg::LEN_W-1:0];
                adsr_pkg::REG_SUSTAIN_LEVEL:
                    cfg_reg.sustain_level <= cfg_data[adsr_pkg::SUS_W-1:0];
                adsr_pkg::REG_RELEASE_LEN:
                    cfg_reg.release_len <= cfg_data[adsr_pkg::LEN_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: rtl/adsr_div.sv
module adsr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  adsr_pkg::div_req_t  req,
    output adsr_pkg::div_rsp_t  rsp
);

    localparam int DW    = adsr_pkg::DIV_W;
    localparam int LW    = adsr_pkg::LEN_W;
    localparam int CNT_W = $clog2(DW);

    logic [DW-1:0]    quo_reg;
    logic [LW-1:0]    rem_reg;
    logic [LW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [LW:0]   trial;
    logic [LW:0]   diff;
    logic          fits;
    logic [LW-1:0] rem_next;
    logic [DW-1:0] quo_next;
    logic          last;

    // one quotient bit a cycle, restoring
    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = fits ? diff[LW-1:0] : trial[LW-1:0];
    assign quo_next = {quo_reg[DW-2:0], fits};
    assign last     = cnt_reg == CNT_W'(DW - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still iterating");

endmodule

FILE: rtl/adsr_ctrl.sv
module adsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  adsr_pkg::cfg_t      cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          item_func,
    input  logic [adsr_pkg::VEL_W-1:0] item_velocity,
    output logic                res_valid,
    input  logic                res_take,
    output adsr_pkg::res_t      res,
    output adsr_pkg::div_req_t  div_req,
    input  adsr_pkg::div_rsp_t  div_rsp
);

    localparam int OW = adsr_pkg::OUT_W;
    localparam int LV = adsr_pkg::LEVEL_W;
    localparam int LW = adsr_pkg::LEN_W;
    localparam int SW = adsr_pkg::SUS_W;
    localparam int DW = adsr_pkg::DIV_W;

    adsr_pkg::state_t state_reg, state_next;

    logic [LV-1:0] env_reg,      env_next;
    logic [OW-1:0] step_atk_reg, step_atk_next;
    logic [OW-1:0] step_dec_reg, step_dec_next;
    logic [OW-1:0] step_rel_reg, step_rel_next;
    logic [OW-1:0] peak_reg,     peak_next;
    logic [OW-1:0] hold_reg,     hold_next;
    logic [1:0]    phase_reg,    phase_next;
    logic          moving_reg,   moving_next;
    logic          done_reg,     done_next;
    logic          rel_reg,      rel_next;
    logic          pulse_reg,    pulse_next;

    logic [LV-1:0]    one_lv;
    logic [LV-1:0]    lvl_clamp;
    logic [LV-1:0]    dn_step;
    logic [OW+SW-1:0] hold_prod;
    logic [OW-1:0]    quo_min1;
    logic [1:0]       phase_adv;
    logic [LW-1:0]    atk_dvs;
    logic [LW-1:0]    dec_dvs;
    logic [LW-1:0]    rel_dvs;

    assign one_lv    = {1'b0, adsr_pkg::ONE_FX};
    assign lvl_clamp = (env_reg > one_lv) ? one_lv : env_reg;
    assign dn_step   = {1'b0, (phase_reg == adsr_pkg::PH_DECAY) ? step_dec_reg : step_rel_reg};
    assign hold_prod = peak_reg * cfg.sustain_level;
    // step is at least one
    assign quo_min1  = (div_rsp.quotient[OW-1:0] == '0) ? OW'(1) : div_rsp.quotient[OW-1:0];
    // zero length counts as one
    assign atk_dvs   = (cfg.attack_len  == '0) ? LW'(1) : cfg.attack_len;
    assign dec_dvs   = (cfg.decay_len   == '0) ? LW'(1) : cfg.decay_len;
    assign rel_dvs   = (cfg.release_len == '0) ? LW'(1) : cfg.release_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= adsr_pkg::S_IDLE;
            env_reg      <= '0;
            step_atk_reg <= '0;
            step_dec_reg <= '0;
            step_rel_reg <= '0;
            peak_reg     <= adsr_pkg::ONE_FX;
            hold_reg     <= adsr_pkg::HOLD_RESET;
            phase_reg    <= adsr_pkg::PH_IDLE;
            moving_reg   <= 1'b0;
            done_reg     <= 1'b1;
            rel_reg      <= 1'b0;
            pulse_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            env_reg      <= env_next;
            step_atk_reg <= step_atk_next;
            step_dec_reg <= step_dec_next;
            step_rel_reg <= step_rel_next;
            peak_reg     <= peak_next;
            hold_reg     <= hold_next;
            phase_reg    <= phase_next;
            moving_reg   <= moving_next;
            done_reg     <= done_next;
            rel_reg      <= rel_next;
            pulse_reg    <= pulse_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        env_next      = env_reg;
        step_atk_next = step_atk_reg;
        step_dec_next = step_dec_reg;
        step_rel_next = step_rel_reg;
        peak_next     = peak_reg;
        hold_next     = hold_reg;
        phase_next    = phase_reg;
        moving_next   = moving_reg;
        done_next     = done_reg;
        rel_next      = rel_reg;
        pulse_next    = pulse_reg;
        phase_adv     = phase_reg;
        item_ready    = 1'b0;
        res_valid     = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {{(DW-OW){1'b0}}, peak_reg};
        div_req.divisor  = atk_dvs;

        case (state_reg)
            adsr_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    pulse_next = 1'b0;
                    case (item_func)
                        adsr_pkg::FUNC_TICK:
                            state_next = (phase_reg == adsr_pkg::PH_IDLE) ?
                                         adsr_pkg::S_RESULT : adsr_pkg::S_TICK_STEP;
                        adsr_pkg::FUNC_NOTE_ON:
                        begin
                            // peak = velocity / 127 in level format
                            div_req.start    = 1'b1;
                            div_req.dividend = {item_velocity,
                                                {adsr_pkg::LEVEL_FRAC_BITS{1'b0}}};
                            div_req.divisor  = adsr_pkg::VEL_SCALE;
                            state_next       = adsr_pkg::S_PEAK_DIV;
                        end
                        adsr_pkg::FUNC_NOTE_OFF:
                        begin
                            if (phase_reg != adsr_pkg::PH_IDLE)
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {{(DW-LV){1'b0}}, lvl_clamp};
                                div_req.divisor  = rel_dvs;
                                state_next       = adsr_pkg::S_REL_DIV;
                            end
                            else
                            begin
                                state_next = adsr_pkg::S_RESULT;
                            end
                        end
                        default:
                            state_next = adsr_pkg::S_RESULT;
                    endcase
                end
            end

            adsr_pkg::S_TICK_STEP:
            begin
                env_next = lvl_clamp;
                if (moving_reg)
                begin
                    if (phase_reg == adsr_pkg::PH_ATTACK)
                        env_next = lvl_clamp + {1'b0, step_atk_reg};
                    else
                        env_next = (lvl_clamp > dn_step) ? (lvl_clamp - dn_step) : '0;
                end
                state_next = adsr_pkg::S_TICK_CHECK;
            end

            adsr_pkg::S_TICK_CHECK:
            begin
                if (((phase_reg == adsr_pkg::PH_ATTACK) && (env_reg >= {1'b0, peak_reg})) ||
                    ((phase_reg == adsr_pkg::PH_HOLD) && (env_reg == '0)))
                begin
                    phase_adv = phase_reg + 2'd1;
                end
                else if ((phase_reg == adsr_pkg::PH_DECAY) && (env_reg <= {1'b0, hold_reg}))
                begin
                    moving_next = 1'b0;
                    phase_adv   = adsr_pkg::PH_HOLD;
                end
                phase_next = phase_adv;
                // envelope finished
                if (phase_adv == adsr_pkg::PH_IDLE)
                begin
                    moving_next = 1'b0;
                    env_next    = '0;
                    done_next   = 1'b1;
                    rel_next    = 1'b0;
                    pulse_next  = 1'b1;
                end
                state_next = adsr_pkg::S_RESULT;
            end

            adsr_pkg::S_PEAK_DIV:
            begin
                if (div_rsp.done)
                begin
                    peak_next  = div_rsp.quotient[OW-1:0];
                    state_next = adsr_pkg::S_HOLD_MUL;
                end
            end

            adsr_pkg::S_HOLD_MUL:
            begin
                hold_next     = hold_prod[SW +: OW];
                div_req.start = 1'b1;
                state_next    = adsr_pkg::S_ATK_DIV;
            end

            adsr_pkg::S_ATK_DIV:
            begin
                if (div_rsp.done)
                begin
                    step_atk_next   = quo_min1;
                    div_req.start   = 1'b1;
                    div_req.divisor = dec_dvs;
                    state_next      = adsr_pkg::S_DEC_DIV;
                end
            end

            adsr_pkg::S_DEC_DIV:
            begin
                if (div_rsp.done)
                begin
                    step_dec_next = quo_min1;
                    moving_next   = 1'b1;
                    done_next     = 1'b0;
                    rel_next      = 1'b0;
                    phase_next    = adsr_pkg::PH_ATTACK;
                    state_next    = adsr_pkg::S_RESULT;
                end
            end

            adsr_pkg::S_REL_DIV:
            begin
                if (div_rsp.done)
                begin
                    step_rel_next = quo_min1;
                    moving_next   = 1'b1;
                    rel_next      = 1'b1;
                    phase_next    = adsr_pkg::PH_HOLD;
                    state_next    = adsr_pkg::S_RESULT;
                end
            end

            adsr_pkg::S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_take)
                    state_next = adsr_pkg::S_IDLE;
            end

            default:
                state_next = adsr_pkg::S_IDLE;
        endcase
    end

    assign res.level        = (env_reg > one_lv) ? adsr_pkg::ONE_FX : env_reg[OW-1:0];
    assign res.phase        = phase_reg;
    assign res.released     = done_reg;
    assign res.releasing    = rel_reg;
    assign res.release_done = pulse_reg;

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == adsr_pkg::S_PEAK_DIV ||
                          state_reg == adsr_pkg::S_ATK_DIV ||
                          state_reg == adsr_pkg::S_DEC_DIV ||
                          state_reg == adsr_pkg::S_REL_DIV))
        else $error("divider result arrived with nobody waiting");

    a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == adsr_pkg::PH_IDLE) |-> !moving_reg)
        else $error("level moving while envelope idle");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && rel_reg))
        else $error("released and releasing both set");

    a_pulse_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_reg |-> (phase_reg == adsr_pkg::PH_IDLE && done_reg))
        else $error("release done pulse outside idle");

endmodule

FILE: rtl/linear_adsr_envelope.sv
// channel  | dir | signals                                   | content
// s_axis   | in  | s_axis_tvalid/tready/tdata[7:0]/tuser[1:0]| velocity; tuser = func
// m_axis   | out | m_axis_tvalid/tready/tdata[31:0]          | level, phase, flags
// cfg      | in  | cfg_valid/ready/index[1:0]/data[19:0]     | 0 attack, 1 decay,
//          |     |                                           | 2 sustain, 3 release
//
// tick: step and check states, then the result handoff (an idle envelope skips to the result)
// note-on: three passes of the shared restoring divider plus the
//   sustain multiply; note-off: one divider pass unless the envelope is idle
// one item in flight; s_axis_tready is high only while the sequencer is idle
// the output register holds a finished item, so the next item is taken while
//   m_axis is stalled; a second result waits in the sequencer until it drains
// rst_n clears the envelope to idle and the registers to 480/480/0.5/480
module linear_adsr_envelope (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] velocity, [7] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [24:0] level, [26:25] phase, [27] released,
                                        // [28] releasing, [29] release_done, [31:30] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data
);

    adsr_pkg::cfg_t     cfg;
    adsr_pkg::div_req_t div_req;
    adsr_pkg::div_rsp_t div_rsp;
    adsr_pkg::res_t     res;

    logic        res_valid;
    logic        out_free;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    // register file
    adsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // shared serial divider: velocity scaling and all three step sizes
    adsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer and envelope state
    adsr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_valid    (s_axis_tvalid),
        .item_ready    (s_axis_tready),
        .item_func     (s_axis_tuser),
        .item_velocity (s_axis_tdata[adsr_pkg::VEL_W-1:0]),
        .res_valid     (res_valid),
        .res_take      (out_free),
        .res           (res),
        .div_req       (div_req),
        .div_rsp       (div_rsp)
    );

    // output register: free when empty or draining this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
            out_data_reg <= {2'b00, res};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
